/* src/dwfo_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dwfo_pkg - shared types and constants
// Constants, payload structs and table interface types for the digit window
// first occurrence recorder.
// ---------------------------------------------------------------------------
package dwfo_pkg;

    localparam int MAX_DIGITS  = 8;
    localparam int TABLE_DEPTH = 4096;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int WIN_AW      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int NUM_W       = $clog2(10 ** MAX_DIGITS);
    localparam int RANGE_W     = 27;
    localparam int CMP_W       = (NUM_W > RANGE_W) ? NUM_W : RANGE_W;
    localparam int POS_W       = 32;
    localparam int FOUND_W     = 13;
    localparam int CFG_W       = 32;

    localparam logic [FOUND_W-1:0] FOUND_MAX = {FOUND_W{1'b1}};
    localparam logic [POS_W-1:0]   START_MAX = {POS_W{1'b1}};
    localparam logic [3:0]         DIGIT_MAX = 4'd9;

    typedef enum logic [2:0] {
        CFG_RANGE_LOW  = 3'd0,
        CFG_RANGE_HIGH = 3'd1,
        CFG_MIN_LEN    = 3'd2,
        CFG_MAX_LEN    = 3'd3,
        CFG_FIRST_POS  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    typedef struct packed {
        logic        action;
        logic [3:0]  digit;
        logic [11:0] entry_index;
    } t_in;

    typedef struct packed {
        logic [FOUND_W-1:0] found_count;
        logic [POS_W-1:0]   digits_checked;
        logic [3:0]         new_marks;
        logic               entry_valid;
        logic [POS_W-1:0]   entry_position;
    } t_out;

    typedef struct packed {
        logic              valid;
        logic              lookup;
        logic [TBL_AW-1:0] addr;
        logic [POS_W-1:0]  pos;
    } t_tbl_req;

    typedef struct packed {
        logic             valid;
        logic             is_new;
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_tbl_rsp;

    typedef struct packed {
        logic             mark;
        logic [POS_W-1:0] pos;
    } t_entry;

endpackage
`default_nettype wire

/* src/digit_window_first_occurrence.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// digit_window_first_occurrence - digit stream first occurrence recorder
// Keeps a window of the latest digits and records, in a table, the first
// window start at which each number in the configured range appears.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// o_res for one cycle with o_done high and must be taken then. After reset the
// table runs a clearing pass over all TABLE_DEPTH (4096) entries with busy high;
// configuration writes are taken during it. A push that leaves the window
// short of max_len digits gives its result in the cycle after it is taken and
// busy stays low. A push with a full window walks the lengths one per cycle
// through a mark-and-store read-modify-write on the single table memory
// (max_len clamped to one to eight), then waits in a drain state until the
// last table access is done; its result comes with the return to idle, and
// the next item can be taken in the result cycle. A read action is one table
// read, with busy high until its result, which is registered from the lookup
// state; the next item can be taken in the result cycle too.
// ---------------------------------------------------------------------------
module digit_window_first_occurrence (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  dwfo_pkg::t_in        i_item,
    output dwfo_pkg::t_out       o_res,
    output logic                 o_done,
    input  wire                  i_cfg_we,
    input  wire  [2:0]           i_cfg_idx,
    input  wire  [dwfo_pkg::CFG_W-1:0] i_cfg_data
);
    import dwfo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_LOOK  = 4'b1000
    } t_state;

    t_state             r_state;

    logic [RANGE_W-1:0] r_range_low;
    logic [RANGE_W-1:0] r_range_high;
    logic [3:0]         r_min_len;
    logic [3:0]         r_max_len;
    logic [POS_W-1:0]   r_first_pos;

    logic [3:0]         r_win [MAX_DIGITS];
    logic [3:0]         r_rcvd;
    logic [POS_W-1:0]   r_start;
    logic [FOUND_W-1:0] r_found;
    logic [3:0]         r_marks;

    logic [3:0]         r_top;
    logic [3:0]         r_bot;
    logic [3:0]         r_len;
    logic [NUM_W-1:0]   r_num;
    logic [POS_W-1:0]   r_pos;
    logic               r_look_ok;

    logic               r_cand_vld;
    logic [NUM_W-1:0]   r_cand_num;
    logic [3:0]         r_cand_len;
    logic               r_req_pend;

    t_out               r_res;
    logic               r_done;

    t_tbl_req           tbl_req;
    t_tbl_rsp           tbl_rsp;
    logic               tbl_clearing;

    logic               accept;
    logic [3:0]         dig_in;
    logic [3:0]         n_rcvd;
    logic [3:0]         top_in;
    logic [3:0]         bot_in;
    logic               idx_ok;
    logic [WIN_AW-1:0]  win_idx;
    logic [NUM_W-1:0]   n_num;
    logic [CMP_W-1:0]   cand_off;
    logic               cand_hit;
    logic [POS_W-1:0]   n_start;

    dwfo_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (tbl_req),
        .o_rsp      (tbl_rsp),
        .o_clearing (tbl_clearing)
    );

    assign busy   = tbl_clearing || (r_state != S_IDLE);
    assign accept = start && !busy;

    assign dig_in = (i_item.digit > DIGIT_MAX) ? DIGIT_MAX : i_item.digit;
    assign n_rcvd = (r_rcvd < 4'(MAX_DIGITS)) ? r_rcvd + 4'd1 : r_rcvd;

    always_comb begin
        if (r_max_len == 4'd0) begin
            top_in = 4'd1;
        end else if (r_max_len > 4'(MAX_DIGITS)) begin
            top_in = 4'(MAX_DIGITS);
        end else begin
            top_in = r_max_len;
        end
        bot_in = (r_min_len == 4'd0) ? 4'd1 : r_min_len;
    end

    assign idx_ok = (32'(i_item.entry_index) < 32'(TABLE_DEPTH));

    // oldest digit of the window first
    assign win_idx = WIN_AW'(r_top - r_len);
    assign n_num   = NUM_W'({r_num, 3'b000}) + NUM_W'({r_num, 1'b0})
                   + NUM_W'(r_win[win_idx]);

    assign cand_off = CMP_W'(r_cand_num) - CMP_W'(r_range_low);
    assign cand_hit = r_cand_vld && (r_cand_len >= r_bot)
                   && (CMP_W'(r_cand_num) >= CMP_W'(r_range_low))
                   && (CMP_W'(r_cand_num) <= CMP_W'(r_range_high))
                   && (cand_off < CMP_W'(TABLE_DEPTH));

    assign n_start = (r_start != START_MAX) ? r_start + POS_W'(1) : r_start;

    always_comb begin
        if (r_state == S_IDLE) begin
            tbl_req.valid  = accept && (i_item.action == ACT_READ) && idx_ok;
            tbl_req.lookup = 1'b1;
            tbl_req.addr   = TBL_AW'(i_item.entry_index);
            tbl_req.pos    = '0;
        end else begin
            tbl_req.valid  = cand_hit;
            tbl_req.lookup = 1'b0;
            tbl_req.addr   = TBL_AW'(cand_off);
            tbl_req.pos    = r_pos;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= RANGE_W'(4095);
            r_min_len    <= 4'd1;
            r_max_len    <= 4'd4;
            r_first_pos  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_LOW:  r_range_low  <= i_cfg_data[RANGE_W-1:0];
                CFG_RANGE_HIGH: r_range_high <= i_cfg_data[RANGE_W-1:0];
                CFG_MIN_LEN:    r_min_len    <= i_cfg_data[3:0];
                CFG_MAX_LEN:    r_max_len    <= i_cfg_data[3:0];
                CFG_FIRST_POS:  r_first_pos  <= i_cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // digit window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_DIGITS; k++) begin
                r_win[k] <= '0;
            end
            r_rcvd <= '0;
        end else if (accept && (i_item.action == ACT_PUSH)) begin
            for (int k = MAX_DIGITS - 1; k > 0; k--) begin
                r_win[k] <= r_win[k-1];
            end
            r_win[0] <= dig_in;
            r_rcvd   <= n_rcvd;
        end
    end

    // sequencer and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_start    <= '0;
            r_found    <= '0;
            r_marks    <= '0;
            r_cand_vld <= 1'b0;
            r_req_pend <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done     <= 1'b0;
            r_cand_vld <= 1'b0;
            r_req_pend <= tbl_req.valid;

            if (tbl_rsp.valid && tbl_rsp.is_new) begin
                r_marks <= r_marks + 4'd1;
                if (r_found != FOUND_MAX) begin
                    r_found <= r_found + FOUND_W'(1);
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_item.action == ACT_READ) begin
                            r_state <= S_LOOK;
                        end else if (n_rcvd >= top_in) begin
                            r_state <= S_SCAN;
                            r_marks <= '0;
                        end else begin
                            // window still filling: answer at once
                            r_done <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    r_cand_vld <= 1'b1;
                    if (r_len == r_top) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_cand_vld && !r_req_pend) begin
                        r_start <= n_start;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_LOOK: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_top     <= top_in;
                    r_bot     <= bot_in;
                    r_len     <= 4'd1;
                    r_num     <= '0;
                    r_pos     <= r_first_pos + r_start;
                    r_look_ok <= idx_ok;
                    r_res.found_count    <= r_found;
                    r_res.digits_checked <= r_start;
                    r_res.new_marks      <= '0;
                    r_res.entry_valid    <= 1'b0;
                    r_res.entry_position <= '0;
                end
            end
            S_SCAN: begin
                r_num      <= n_num;
                r_cand_num <= n_num;
                r_cand_len <= r_len;
                r_len      <= r_len + 4'd1;
            end
            S_DRAIN: begin
                r_res.found_count    <= r_found;
                r_res.digits_checked <= n_start;
                r_res.new_marks      <= r_marks;
                r_res.entry_valid    <= 1'b0;
                r_res.entry_position <= '0;
            end
            S_LOOK: begin
                r_res.found_count    <= r_found;
                r_res.digits_checked <= r_start;
                r_res.new_marks      <= '0;
                r_res.entry_valid    <= r_look_ok && tbl_rsp.hit;
                r_res.entry_position <= (r_look_ok && tbl_rsp.hit) ? tbl_rsp.pos : '0;
            end
            default: begin
            end
        endcase
    end

    assign o_res  = r_res;
    assign o_done = r_done;

`ifndef NO_ASSERTIONS
    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted beat neither in work nor answered");

    a_rsp_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_rsp.valid |-> $past(tbl_req.valid))
        else $error("table response without a request");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_cand_vld && !r_req_pend))
        else $error("idle with table access still in flight");
`endif

endmodule
`default_nettype wire

/* src/dwfo_table.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dwfo_table - first occurrence table
// One synchronous memory of mark and position per entry. Test-and-set with a
// registered read, forwarding of the write made in the previous cycle, plain
// lookups, and a clearing pass over every entry after reset.
// ---------------------------------------------------------------------------
module dwfo_table (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dwfo_pkg::t_tbl_req  i_req,
    output dwfo_pkg::t_tbl_rsp  o_rsp,
    output logic                o_clearing
);
    import dwfo_pkg::*;

    t_entry            mem [TABLE_DEPTH];
    t_entry            r_rd;

    logic              r_clr;
    logic [TBL_AW-1:0] r_clr_idx;

    logic              r_s1_vld;
    logic              r_s1_lookup;
    logic [TBL_AW-1:0] r_s1_addr;
    logic [POS_W-1:0]  r_s1_pos;

    logic              r_fw_en;
    logic [TBL_AW-1:0] r_fw_addr;
    logic [POS_W-1:0]  r_fw_pos;

    logic              fw_hit;
    logic              mark_old;
    logic              set_now;
    logic              wr_en;
    logic [TBL_AW-1:0] wr_addr;
    t_entry            wr_data;

    // the write of the previous cycle is not yet in the read data
    assign fw_hit   = r_fw_en && (r_fw_addr == r_s1_addr);
    assign mark_old = r_rd.mark || fw_hit;
    assign set_now  = r_s1_vld && !r_s1_lookup && !mark_old;

    always_comb begin
        if (r_clr) begin
            wr_en        = 1'b1;
            wr_addr      = r_clr_idx;
            wr_data.mark = 1'b0;
            wr_data.pos  = '0;
        end else begin
            wr_en        = set_now;
            wr_addr      = r_s1_addr;
            wr_data.mark = 1'b1;
            wr_data.pos  = r_s1_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_rd <= mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            r_s1_vld  <= 1'b0;
            r_fw_en   <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + TBL_AW'(1);
                if (r_clr_idx == TBL_AW'(TABLE_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_s1_vld <= i_req.valid;
            r_fw_en  <= set_now;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_lookup <= i_req.lookup;
        r_s1_addr   <= i_req.addr;
        r_s1_pos    <= i_req.pos;
        r_fw_addr   <= r_s1_addr;
        r_fw_pos    <= r_s1_pos;
    end

    always_comb begin
        o_rsp.valid  = r_s1_vld;
        o_rsp.is_new = set_now;
        o_rsp.hit    = mark_old;
        o_rsp.pos    = fw_hit ? r_fw_pos : r_rd.pos;
    end

    assign o_clearing = r_clr;

endmodule
`default_nettype wire
